[rtl/base64_stream_encoder_top_assert.svh]
// Assertion macros shared by the encoder modules.
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/b64e_pkg.sv]
package b64e_pkg;

	localparam int ByteW   = 8;
	localparam int SextetW = 6;
	localparam int CharW   = 7;
	localparam int GroupW  = 3 * ByteW;

	// ASCII anchors of the alphabet ranges
	localparam logic [CharW-1:0] CharUpperA = 7'h41;
	localparam logic [CharW-1:0] CharLowerA = 7'h61;
	localparam logic [CharW-1:0] CharZero   = 7'h30;
	localparam logic [CharW-1:0] CharPlus   = 7'h2B;
	localparam logic [CharW-1:0] CharSlash  = 7'h2F;
	localparam logic [CharW-1:0] CharPad    = 7'h3D;

	// One closed group on its way from front to back
	typedef struct packed {
		logic [GroupW-1:0] word;    // zero-filled, first byte in the top bits
		logic [1:0]        nbytes;  // data bytes in the group, 1..3
		logic              fin;     // group closes the message
	} grp_t;

	// Map a six-bit value to its base64 character
	function automatic logic [CharW-1:0] b64e_char(input logic [SextetW-1:0] s);
		logic [CharW-1:0] v;
		v = {1'b0, s};
		if (s < 6'd26)
			return CharUpperA + v;
		else if (s < 6'd52)
			return CharLowerA + v - 7'd26;
		else if (s < 6'd62)
			return CharZero + v - 7'd52;
		else if (s == 6'd62)
			return CharPlus;
		else
			return CharSlash;
	endfunction

endpackage

[rtl/base64_stream_encoder_top.sv]
// Base64 encoder: bytes in, one ASCII character out per cycle while a group is queued and out_ready allows.
// A closing transfer queues its group; its first character then enters the output register.
// Each three-byte group gives four characters, so the single character output register
// sets the sustained rate; a two-group queue absorbs input bursts.
// Reset (arst_n low, asynchronous): held bytes, queue and output valid clear at once.
module base64_stream_encoder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [b64e_pkg::ByteW-1:0] data_byte,
	input  logic                       final_byte,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic [b64e_pkg::CharW-1:0] out_char,
	output logic                       group_end,
	output logic                       message_end,
	output logic                       out_valid,
	input  logic                       out_ready
);
	import b64e_pkg::*;

	grp_t push_grp;
	grp_t head_grp;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	// Gather bytes into groups
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_grp      (push_grp)
	);

	// Decouple the byte side from the character side
	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_grp (push_grp),
		.pop      (q_pop),
		.head_grp (head_grp),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Emit four characters per group
	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_grp    (head_grp),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.out_char    (out_char),
		.group_end   (group_end),
		.message_end (message_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

[rtl/b64e_front.sv]
module b64e_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [b64e_pkg::ByteW-1:0] data_byte,
	input  logic                     final_byte,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     q_full,
	output logic                     q_push,
	output b64e_pkg::grp_t           q_grp
);
	import b64e_pkg::*;

	`include "base64_stream_encoder_top_assert.svh"

	logic [2*ByteW-1:0] held_q;
	logic [1:0]         held_cnt_q;
	logic               accept;
	logic               close_grp;

	// Take a byte whenever the queue has room
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign close_grp = (held_cnt_q >= 2'd2) || final_byte;
	assign q_push    = accept && close_grp;

	// Build the zero-filled group from the held bytes and the new byte
	always_comb begin
		q_grp.fin = final_byte;
		case (held_cnt_q)
			2'd0: begin
				q_grp.word   = {data_byte, {(2*ByteW){1'b0}}};
				q_grp.nbytes = 2'd1;
			end
			2'd1: begin
				q_grp.word   = {held_q[ByteW-1:0], data_byte, {ByteW{1'b0}}};
				q_grp.nbytes = 2'd2;
			end
			default: begin
				q_grp.word   = {held_q, data_byte};
				q_grp.nbytes = 2'd3;
			end
		endcase
	end

	// Hold pending bytes, empty them when a group closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= '0;
		end else if (accept) begin
			if (close_grp) begin
				held_q     <= '0;
				held_cnt_q <= '0;
			end else begin
				held_q     <= {held_q[ByteW-1:0], data_byte};
				held_cnt_q <= held_cnt_q + 2'd1;
			end
		end
	end

	`B64E_ASSERT_NEXT(a_front_empty_after_push, clk, arst_n, q_push, held_cnt_q == 2'd0, "held bytes remain after group push")
	`B64E_ASSERT_NOW(a_front_cnt_range, clk, arst_n, 1'b1, held_cnt_q != 2'd3, "held count reached three")

endmodule

[rtl/b64e_queue.sv]
module b64e_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::grp_t push_grp,
	input  logic           pop,
	output b64e_pkg::grp_t head_grp,
	output logic           full,
	output logic           empty
);
	import b64e_pkg::*;

	`include "base64_stream_encoder_top_assert.svh"

	grp_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign head_grp = slot_q[rd_ptr_q];

	// Store pushed groups
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_grp;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	`B64E_ASSERT_NOW(a_queue_no_overflow, clk, arst_n, push, !full || pop, "push into full queue")
	`B64E_ASSERT_NOW(a_queue_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")

endmodule

[rtl/b64e_back.sv]
module b64e_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  b64e_pkg::grp_t             head_grp,
	input  logic                       q_empty,
	output logic                       q_pop,
	output logic [b64e_pkg::CharW-1:0] out_char,
	output logic                       group_end,
	output logic                       message_end,
	output logic                       out_valid,
	input  logic                       out_ready
);
	import b64e_pkg::*;

	`include "base64_stream_encoder_top_assert.svh"

	logic [1:0]         idx_q;
	logic               out_valid_q;
	logic [CharW-1:0]   char_q;
	logic               grp_end_q;
	logic               msg_end_q;
	logic               load;
	logic               last_char;
	logic [SextetW-1:0] sextet;
	logic [CharW-1:0]   next_char;

	assign load      = !q_empty && (!out_valid_q || out_ready);
	assign last_char = (idx_q == 2'd3);
	assign q_pop     = load && last_char;

	// Pick the sextet of the current character, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    sextet = head_grp.word[4*SextetW-1:3*SextetW];
			2'd1:    sextet = head_grp.word[3*SextetW-1:2*SextetW];
			2'd2:    sextet = head_grp.word[2*SextetW-1:SextetW];
			default: sextet = head_grp.word[SextetW-1:0];
		endcase
		next_char = (idx_q > head_grp.nbytes) ? CharPad : b64e_char(sextet);
	end

	// Step through the four characters of the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= idx_q + 2'd1;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the output character until its transfer
	always_ff @(posedge clk) begin
		if (load) begin
			char_q    <= next_char;
			grp_end_q <= last_char;
			msg_end_q <= last_char && head_grp.fin;
		end
	end

	assign out_char    = char_q;
	assign group_end   = grp_end_q;
	assign message_end = msg_end_q;
	assign out_valid   = out_valid_q;

	`B64E_ASSERT_NOW(a_back_msg_on_grp_end, clk, arst_n, out_valid_q && msg_end_q, grp_end_q, "message end off a group end")
	`B64E_ASSERT_NEXT(a_back_idx_wrap, clk, arst_n, q_pop, idx_q == 2'd0, "character index did not wrap")

endmodule

[sim/base64_encoder_checker.sv]
`timescale 1ns / 1ps

module base64_encoder_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [b64e_pkg::ByteW-1:0] data_byte,
	input  logic                       final_byte,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [b64e_pkg::CharW-1:0] out_char,
	input  logic                       group_end,
	input  logic                       message_end,
	input  logic                       out_valid,
	input  logic                       out_ready,
	output int                         fail_count,
	output int                         pending
);

	// Standard alphabet, pad character at index 64; first character in the top byte
	localparam logic [8*65-1:0] B64Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
	localparam int PadIndex = 64;

	typedef struct packed {
		logic [b64e_pkg::CharW-1:0] ch;
		logic                       grp_end;
		logic                       msg_end;
	} encoded_char_t;

	encoded_char_t expected_chars[$];
	logic [15:0]   held_bytes;
	logic [1:0]    held_count;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int exp);
		$display("mismatch at %0t: %s got 'h%0h expected 'h%0h", $realtime, what, got, exp);
		fail_count = fail_count + 1;
	endtask

	// Hold bytes until a group closes, then queue its four characters
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [23:0]   group_word;
		int            nbytes;
		int            idx;
		encoded_char_t c;
		if (held_count < 2'd2 && !fin) begin
			held_bytes = {held_bytes[7:0], b};
			held_count = held_count + 2'd1;
		end else begin
			// a count of three never occurs; treat it like two held bytes
			case (held_count)
				2'd0: begin
					nbytes     = 1;
					group_word = {b, 16'h0000};
				end
				2'd1: begin
					nbytes     = 2;
					group_word = {held_bytes[7:0], b, 8'h00};
				end
				default: begin
					nbytes     = 3;
					group_word = {held_bytes, b};
				end
			endcase
			for (int i = 0; i < 4; i++) begin
				if (i > nbytes)
					idx = PadIndex;
				else
					idx = int'(group_word[(3-i)*6 +: 6]);
				c.ch      = B64Alphabet[(64-idx)*8 +: 7];
				c.grp_end = (i == 3);
				c.msg_end = (i == 3) && fin;
				expected_chars.push_back(c);
			end
			held_bytes = 16'h0000;
			held_count = 2'd0;
		end
	endtask

	// Check the character transfer first, then predict from the byte transfer
	always @(posedge clk or negedge arst_n) begin
		encoded_char_t e;
		if (!arst_n) begin
			expected_chars.delete();
			held_bytes = 16'h0000;
			held_count = 2'd0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("character with nothing expected", int'(out_char), 0);
				end else begin
					e = expected_chars.pop_front();
					if (out_char !== e.ch)
						report_mismatch("out_char", int'(out_char), int'(e.ch));
					if (group_end !== e.grp_end)
						report_mismatch("group_end", int'(group_end), int'(e.grp_end));
					if (message_end !== e.msg_end)
						report_mismatch("message_end", int'(message_end), int'(e.msg_end));
				end
			end
			if (in_valid && in_ready)
				encode_byte(data_byte, final_byte);
		end
		pending = expected_chars.size();
	end

endmodule

[sim/tb_base64_stream_encoder_top.sv]
`timescale 1ns / 1ps

module tb_base64_stream_encoder_top;

	localparam int DirectedCount = 24;
	localparam int RandomBytes   = 126;
	localparam int LongHoldStart = 40;
	localparam int LongHoldLen   = 80;

	logic                       clk;
	logic                       arst_n;
	logic [b64e_pkg::ByteW-1:0] data_byte;
	logic                       final_byte;
	logic                       in_valid;
	logic                       in_ready;
	logic [b64e_pkg::CharW-1:0] out_char;
	logic                       group_end;
	logic                       message_end;
	logic                       out_valid;
	logic                       out_ready;
	int                         fail_count;
	int                         pending;

	int bytes_sent;
	bit quiet_phase;
	bit long_hold_done;

	// {final, byte}: single bytes, pairs, full groups giving '+' and '/', longer messages
	logic [8:0] directed_bytes [DirectedCount] = '{
		{1'b1, 8'h00},
		{1'b1, 8'hFF},
		{1'b0, 8'hFF}, {1'b1, 8'hFF},
		{1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00},
		{1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b1, 8'hBE},
		{1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
		{1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E}, {1'b1, 8'h41},
		{1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h04}, {1'b0, 8'h08}, {1'b1, 8'h10},
		{1'b0, 8'h80}, {1'b1, 8'h40}
	};

	base64_stream_encoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_char   (out_char),
		.group_end  (group_end),
		.message_end(message_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	base64_encoder_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_char   (out_char),
		.group_end  (group_end),
		.message_end(message_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offer one byte, idling first at random; return at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		bytes_sent = bytes_sent + 1;
		@(negedge clk);
	endtask

	// Drain characters with random stalls and one long hold-off to back up the queue
	initial begin : receiver
		int unsigned n;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && bytes_sent >= LongHoldStart) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				for (n = 0; n < LongHoldLen; n++)
					@(negedge clk);
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	// Reset, directed messages, random messages, then drain and judge
	initial begin : stimulus
		int msg_len;
		int k;
		logic [7:0] b;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = '0;
		final_byte     = 1'b0;
		bytes_sent     = 0;
		quiet_phase    = 1'b0;
		long_hold_done = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DirectedCount; k++)
			send_byte(directed_bytes[k][7:0], directed_bytes[k][8]);

		// mostly short messages, some long ones, bytes biased toward the extremes
		while (bytes_sent < DirectedCount + RandomBytes) begin
			msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) :
				$urandom_range(1, 9);
			for (k = 0; k < msg_len; k++) begin
				case ($urandom_range(0, 7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom);
				endcase
				if (bytes_sent >= DirectedCount + RandomBytes - 30)
					quiet_phase = 1'b1;
				send_byte(b, k == msg_len - 1);
			end
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
